// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the parser RTL (fcp_parser.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define FCP_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FCP_ASSERT_ALW(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/fcp_pkg.sv -----
// Shared types and constants of the framed command packet parser.
package fcp_pkg;

	// Reset values of the configuration registers
	localparam logic [7:0] HEADER_RST   = 8'hFE;
	localparam logic [7:0] TEXT_CMD_RST = 8'hB1;
	localparam logic [7:0] LAMP_CMD_RST = 8'hA2;

	// Most text bytes streamed for one frame
	localparam int MAX_RESULTS = 64;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_HEADER   = 2'd0;
	localparam logic [1:0] REG_TEXT_CMD = 2'd1;
	localparam logic [1:0] REG_LAMP_CMD = 2'd2;

	typedef enum logic [2:0] {
		ST_TEXT    = 3'd0,
		ST_LAMP    = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_SUMERR  = 3'd3,
		ST_LENERR  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEN,
		PH_CMD,
		PH_DATA,
		PH_SUM,
		PH_LAMP_RD,
		PH_TXT_FIRST,
		PH_TXT_STREAM,
		PH_TXT_LAST
	} phase_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] text_command;
		logic [7:0] lamp_command;
	} cfg_t;

endpackage

// ----- rtl/core/fcp_regs.sv -----
// APB configuration registers: header byte and the two command codes.
module fcp_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output fcp_pkg::cfg_t cfg
);
	import fcp_pkg::*;

	logic [7:0] header_q;
	logic [7:0] text_cmd_q;
	logic [7:0] lamp_cmd_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RST;
			text_cmd_q <= TEXT_CMD_RST;
			lamp_cmd_q <= LAMP_CMD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER:   header_q   <= pwdata[7:0];
				REG_TEXT_CMD: text_cmd_q <= pwdata[7:0];
				REG_LAMP_CMD: lamp_cmd_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_HEADER:   prdata = {24'd0, header_q};
			REG_TEXT_CMD: prdata = {24'd0, text_cmd_q};
			REG_LAMP_CMD: prdata = {24'd0, lamp_cmd_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.header_byte  = header_q;
	assign cfg.text_command = text_cmd_q;
	assign cfg.lamp_command = lamp_cmd_q;

endmodule

// ----- rtl/core/fcp_mem.sv -----
// Payload store: one write port, one registered read port.
module fcp_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write a payload word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/fcp_parser.sv -----
// Frame parser, checksum check and result sequencer around the payload store.
`include "assert_macros.svh"
module fcp_parser #(
	parameter int MAX_PAYLOAD = 64,
	parameter int AW          = 6,
	parameter int LEN_W       = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fcp_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [7:0]      command_code,
	output logic [7:0]      text_byte,
	output logic            byte_valid,
	output logic [5:0]      byte_index,
	output logic            last,
	output logic            lamp_on,
	output logic            mem_wr_en,
	output logic [AW-1:0]   mem_wr_addr,
	output logic [7:0]      mem_wr_data,
	output logic            mem_rd_en,
	output logic [AW-1:0]   mem_rd_addr,
	input  logic [7:0]      mem_rd_data
);
	import fcp_pkg::*;

	localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);
	localparam logic [6:0] RES_CAP = 7'(MAX_RESULTS);

	phase_t            state_q, state_d;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [7:0]        cmd_q;
	logic [7:0]        sum_q;
	logic              lamp_q;
	logic [7:0]        cur_q;
	logic [5:0]        idx_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [7:0]        out_cmd_q;
	logic [7:0]        out_byte_q;
	logic              out_bvalid_q;
	logic [5:0]        out_idx_q;
	logic              out_last_q;
	logic              out_lamp_q;

	logic              in_acc;
	logic              out_free;
	logic              len_bad;
	logic              sum_ok;
	logic              is_text;
	logic              is_lamp;
	logic [6:0]        limit;
	logic [6:0]        idx_next;
	logic [6:0]        idx_after;
	logic              rd_zero;
	logic [7:0]        sum_add;

	logic              ld;
	status_t           ld_status;
	logic [7:0]        ld_cmd;
	logic [7:0]        ld_byte;
	logic              ld_bvalid;
	logic [5:0]        ld_idx;
	logic              ld_last;
	logic              ld_lamp;
	logic [6:0]        rd_idx;

	assign out_free  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign len_bad   = {1'b0, rx_byte} > MAX_LEN;
	assign sum_add   = sum_q + rx_byte;
	assign sum_ok    = rx_byte == sum_q;
	assign is_text   = cmd_q == cfg.text_command;
	assign is_lamp   = cmd_q == cfg.lamp_command;
	assign limit     = (9'(len_q) > 9'(RES_CAP)) ? RES_CAP : 7'(len_q);
	assign idx_next  = 7'(idx_q) + 7'd1;
	assign idx_after = 7'(idx_q) + 7'd2;
	assign rd_zero   = mem_rd_data == 8'd0;

	// Accept input only in the parse phases and with room for a result
	always_comb begin
		case (state_q)
			PH_IDLE, PH_LEN, PH_CMD, PH_DATA, PH_SUM: in_ready = out_free;
			default:                                  in_ready = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			PH_IDLE: begin
				if (in_acc && rx_byte == cfg.header_byte) state_d = PH_LEN;
			end
			PH_LEN: begin
				if (in_acc) state_d = len_bad ? PH_IDLE : PH_CMD;
			end
			PH_CMD: begin
				if (in_acc) state_d = (len_q != '0) ? PH_DATA : PH_SUM;
			end
			PH_DATA: begin
				if (in_acc && (cnt_q + LEN_W'(1)) >= len_q) state_d = PH_SUM;
			end
			PH_SUM: begin
				if (in_acc) begin
					if (!sum_ok) state_d = PH_IDLE;
					else if (is_text) state_d = (len_q != '0) ? PH_TXT_FIRST : PH_IDLE;
					else if (is_lamp) state_d = PH_LAMP_RD;
					else state_d = PH_IDLE;
				end
			end
			PH_LAMP_RD: state_d = PH_IDLE;
			PH_TXT_FIRST: begin
				state_d = (rd_zero || limit == 7'd1) ? PH_IDLE : PH_TXT_STREAM;
			end
			PH_TXT_STREAM: begin
				if (out_free) begin
					if (rd_zero) state_d = PH_IDLE;
					else if (idx_after == limit) state_d = PH_TXT_LAST;
				end
			end
			PH_TXT_LAST: begin
				if (out_free) state_d = PH_IDLE;
			end
			default: state_d = PH_IDLE;
		endcase
	end

	// Result loads and store accesses per state
	always_comb begin
		ld        = 1'b0;
		ld_status = ST_TEXT;
		ld_cmd    = cmd_q;
		ld_byte   = 8'd0;
		ld_bvalid = 1'b0;
		ld_idx    = 6'd0;
		ld_last   = 1'b1;
		ld_lamp   = lamp_q;
		mem_rd_en = 1'b0;
		rd_idx    = 7'd0;
		case (state_q)
			PH_LEN: begin
				if (in_acc && len_bad) begin
					ld        = 1'b1;
					ld_status = ST_LENERR;
					ld_cmd    = 8'd0;
				end
			end
			PH_SUM: begin
				if (in_acc) begin
					if (!sum_ok) begin
						ld        = 1'b1;
						ld_status = ST_SUMERR;
					end else if (is_text) begin
						ld        = len_q == '0;
						mem_rd_en = len_q != '0;
					end else if (is_lamp) begin
						mem_rd_en = 1'b1;
					end else begin
						ld        = 1'b1;
						ld_status = ST_UNKNOWN;
					end
				end
			end
			PH_LAMP_RD: begin
				ld        = 1'b1;
				ld_status = ST_LAMP;
				ld_lamp   = !rd_zero;
			end
			PH_TXT_FIRST: begin
				if (rd_zero) begin
					ld = 1'b1;
				end else if (limit == 7'd1) begin
					ld        = 1'b1;
					ld_byte   = mem_rd_data;
					ld_bvalid = 1'b1;
				end else begin
					mem_rd_en = 1'b1;
					rd_idx    = 7'd1;
				end
			end
			PH_TXT_STREAM: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_byte   = cur_q;
					ld_bvalid = 1'b1;
					ld_idx    = idx_q;
					ld_last   = rd_zero;
					mem_rd_en = !rd_zero && idx_after != limit;
					rd_idx    = idx_after;
				end
			end
			PH_TXT_LAST: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_byte   = cur_q;
					ld_bvalid = 1'b1;
					ld_idx    = idx_q;
				end
			end
			default: ;
		endcase
	end

	assign mem_rd_addr = AW'(rd_idx);
	assign mem_wr_en   = (state_q == PH_DATA) && in_acc;
	assign mem_wr_addr = AW'(cnt_q);
	assign mem_wr_data = rx_byte;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PH_IDLE;
			lamp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == PH_LAMP_RD) lamp_q <= !rd_zero;
			if (ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Frame fields, running checksum and text cursor
	always_ff @(posedge clk) begin
		case (state_q)
			PH_IDLE: if (in_acc) sum_q <= 8'd0;
			PH_LEN: begin
				if (in_acc) begin
					len_q <= LEN_W'(rx_byte);
					sum_q <= sum_add;
				end
			end
			PH_CMD: begin
				if (in_acc) begin
					cmd_q <= rx_byte;
					sum_q <= sum_add;
					cnt_q <= '0;
				end
			end
			PH_DATA: begin
				if (in_acc) begin
					sum_q <= sum_add;
					cnt_q <= cnt_q + LEN_W'(1);
				end
			end
			PH_TXT_FIRST: begin
				cur_q <= mem_rd_data;
				idx_q <= 6'd0;
			end
			PH_TXT_STREAM: begin
				if (out_free && !rd_zero) begin
					cur_q <= mem_rd_data;
					idx_q <= 6'(idx_next);
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ld) begin
			out_status_q <= ld_status;
			out_cmd_q    <= ld_cmd;
			out_byte_q   <= ld_byte;
			out_bvalid_q <= ld_bvalid;
			out_idx_q    <= ld_idx;
			out_last_q   <= ld_last;
			out_lamp_q   <= ld_lamp;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign command_code = out_cmd_q;
	assign text_byte    = out_byte_q;
	assign byte_valid   = out_bvalid_q;
	assign byte_index   = out_idx_q;
	assign last         = out_last_q;
	assign lamp_on      = out_lamp_q;

	`FCP_ASSERT_RST(a_no_overwrite, clk, arst_n, ld |-> out_free, "result overwritten")
	`FCP_ASSERT_RST(a_wr_in_frame, clk, arst_n, mem_wr_en |-> cnt_q < len_q, "store write past length")
	`FCP_ASSERT_RST(a_text_nonzero, clk, arst_n, (out_valid_q && out_bvalid_q) |-> out_byte_q != 8'd0, "zero text byte streamed")
	`FCP_ASSERT_RST(a_rd_then_use, clk, arst_n, (state_q == PH_TXT_FIRST || state_q == PH_LAMP_RD) |-> $past(mem_rd_en), "store data used without read")

endmodule

// ----- rtl/core/framed_command_packet_parser.sv -----
// Top level of the framed command packet parser.
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received word per
//   handshake. Frames are header, length, command, payload, checksum; the
//   checksum is the 8-bit wrapping sum of length, command and payload.
//   Output channel (out_valid/out_ready) carries result words: status,
//   command_code, text_byte, byte_valid, byte_index, last, lamp_on.
//   APB port: header_byte at 0x0, text_command at 0x4, lamp_command at 0x8.
// Timing:
//   Parse words are taken one per cycle while the output register is free.
//   Error, unknown and zero-length text results appear in the cycle after the
//   word that causes them. Lamp results, and text that starts with a zero
//   word or holds a single word, come from the store read issued with the
//   checksum word; the first word of longer text passes through cur_q. Text
//   then streams one word per cycle from the payload memory while the output
//   register is free, one registered read per word; no new input is taken
//   while a frame's text or lamp result is still being produced.
// Reset: arst_n clears the parser to idle, lamp off, output empty, and loads
//   the register defaults. The payload memory is not cleared.
// Stall: with out_ready low the result word holds and input is held off.
module framed_command_packet_parser #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  command_code,
	output logic [7:0]  text_byte,
	output logic        byte_valid,
	output logic [5:0]  byte_index,
	output logic        last,
	output logic        lamp_on
);
	import fcp_pkg::*;

	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	cfg_t          cfg;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [7:0]    mem_wr_data;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [7:0]    mem_rd_data;

	fcp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fcp_mem #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	fcp_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW),
		.LEN_W       (LEN_W)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.command_code (command_code),
		.text_byte    (text_byte),
		.byte_valid   (byte_valid),
		.byte_index   (byte_index),
		.last         (last),
		.lamp_on      (lamp_on),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the framed command packet parser.
module tb_top;
	import fcp_pkg::*;

	localparam int PAYLOAD_MAX = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		status_t    status;
		logic [7:0] command_code;
		logic [7:0] text_byte;
		logic       byte_valid;
		logic [5:0] byte_index;
		logic       last;
		logic       lamp_on;
	} parse_result_t;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  command_code;
	logic [7:0]  text_byte;
	logic        byte_valid;
	logic [5:0]  byte_index;
	logic        last;
	logic        lamp_on;

	// Register copies and parser state of the predictor
	logic [7:0] hdr_cfg = HEADER_RST;
	logic [7:0] text_cfg = TEXT_CMD_RST;
	logic [7:0] lamp_cfg = LAMP_CMD_RST;
	phase_t     pr_phase = PH_IDLE;
	logic [6:0] pr_len = '0;
	logic [7:0] pr_cmd = '0;
	logic [6:0] pr_count = '0;
	logic [7:0] pr_sum = '0;
	logic [7:0] pr_store [PAYLOAD_MAX];
	logic       pr_lamp = 1'b0;
	bit         store0_written = 1'b0;

	parse_result_t pending_results[$];
	int parsed_words = 0;
	int fail_count = 0;

	// Traffic shaping knobs
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int hold_left = 0;

	framed_command_packet_parser #(.MAX_PAYLOAD(PAYLOAD_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .command_code(command_code), .text_byte(text_byte),
		.byte_valid(byte_valid), .byte_index(byte_index), .last(last),
		.lamp_on(lamp_on)
	);

	always #5 clk = ~clk;

	// Queue one expected result word, lamp state taken as it stands now
	function automatic void push_result(status_t st, logic [7:0] cmd, logic [7:0] tbyte,
		logic valid, logic [5:0] idx, logic lst);
		parse_result_t r;
		r.status = st;
		r.command_code = cmd;
		r.text_byte = tbyte;
		r.byte_valid = valid;
		r.byte_index = idx;
		r.last = lst;
		r.lamp_on = pr_lamp;
		pending_results.push_back(r);
	endfunction

	// Check the frame sum, then work out the frame's results
	function automatic void close_frame(logic [7:0] sum_byte);
		int n;
		n = 0;
		if (sum_byte != pr_sum) begin
			push_result(ST_SUMERR, pr_cmd, 8'h00, 1'b0, 6'd0, 1'b1);
		end else if (pr_cmd == text_cfg) begin
			// stream up to the first zero byte
			while (n < pr_len && n < PAYLOAD_MAX && n < MAX_RESULTS
				&& pr_store[n] != 8'h00)
				n++;
			if (n == 0)
				push_result(ST_TEXT, pr_cmd, 8'h00, 1'b0, 6'd0, 1'b1);
			for (int i = 0; i < n; i++)
				push_result(ST_TEXT, pr_cmd, pr_store[i], 1'b1, 6'(i), i == n - 1);
		end else if (pr_cmd == lamp_cfg) begin
			pr_lamp = (pr_store[0] >= 8'd1);
			push_result(ST_LAMP, pr_cmd, 8'h00, 1'b0, 6'd0, 1'b1);
		end else begin
			push_result(ST_UNKNOWN, pr_cmd, 8'h00, 1'b0, 6'd0, 1'b1);
		end
	endfunction

	// Advance the predictor by one accepted word
	function automatic void parse_word(logic [7:0] b);
		if (!(pr_phase == PH_IDLE && b != hdr_cfg))
			parsed_words++;
		case (pr_phase)
			PH_IDLE: begin
				if (b == hdr_cfg) begin
					pr_sum = 8'h00;
					pr_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b > PAYLOAD_MAX) begin
					pr_phase = PH_IDLE;
					push_result(ST_LENERR, 8'h00, 8'h00, 1'b0, 6'd0, 1'b1);
				end else begin
					pr_len = b[6:0];
					pr_sum = pr_sum + b;
					pr_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				pr_cmd = b;
				pr_sum = pr_sum + b;
				pr_count = '0;
				pr_phase = (pr_len > 0) ? PH_DATA : PH_SUM;
			end
			PH_DATA: begin
				if (pr_count < PAYLOAD_MAX)
					pr_store[pr_count] = b;
				if (pr_count == 0)
					store0_written = 1'b1;
				pr_sum = pr_sum + b;
				pr_count = pr_count + 7'd1;
				if (pr_count >= pr_len)
					pr_phase = PH_SUM;
			end
			PH_SUM: begin
				pr_phase = PH_IDLE;
				close_frame(b);
			end
			default: pr_phase = PH_IDLE;
		endcase
	endfunction

	// Offer one word, idling first at random; valid stays high on return
	task automatic send_word(input logic [7:0] b);
		logic [7:0] w;
		w = b;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		// steer clear of a lamp frame that would read a never written payload byte
		if (!store0_written && pr_phase == PH_SUM && pr_len == 0 && pr_cmd == lamp_cfg
			&& pr_cmd != text_cfg && w == pr_sum)
			w = w ^ 8'h01;
		in_valid <= 1'b1;
		rx_byte <= w;
		do @(posedge clk); while (!in_ready);
		parse_word(w);
	endtask

	// Finish any open frame so the parser sits idle
	task automatic park_parser();
		while (pr_phase != PH_IDLE)
			send_word(pr_phase == PH_LEN ? 8'hFF : 8'($urandom));
	endtask

	// Hold the input and wait for every expected word
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic quiesce();
		park_parser();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HEADER:   hdr_cfg = val;
			REG_TEXT_CMD: text_cfg = val;
			REG_LAMP_CMD: lamp_cfg = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [7:0] h, input logic [7:0] t,
		input logic [7:0] l);
		quiesce();
		write_reg(REG_HEADER, h);
		write_reg(REG_TEXT_CMD, t);
		write_reg(REG_LAMP_CMD, l);
	endtask

	function automatic byte_q_t random_body(int len, int zero_pos, bit any_value);
		byte_q_t q;
		for (int i = 0; i < len; i++) begin
			if (i == zero_pos)
				q.push_back(8'h00);
			else if (any_value)
				q.push_back(8'($urandom));
			else
				q.push_back(8'($urandom_range(1, 255)));
		end
		return q;
	endfunction

	// Send a whole frame from the idle state, optionally with a broken sum
	task automatic send_frame(input logic [7:0] cmd, input byte_q_t body,
		input bit bad_sum);
		logic [7:0] sum;
		park_parser();
		sum = 8'(body.size()) + cmd;
		foreach (body[i])
			sum = sum + body[i];
		if (bad_sum)
			sum = sum ^ (8'h01 << $urandom_range(7));
		send_word(hdr_cfg);
		send_word(8'(body.size()));
		send_word(cmd);
		foreach (body[i])
			send_word(body[i]);
		send_word(sum);
	endtask

	// One random episode: mostly whole frames, some noise and broken frames
	task automatic random_episode();
		int pick;
		int len;
		int zpos;
		logic [7:0] cmd;
		pick = $urandom_range(99);
		len = $urandom_range(99);
		if (len < 75)
			len = $urandom_range(0, 6);
		else if (len < 93)
			len = $urandom_range(7, 20);
		else
			len = $urandom_range(21, PAYLOAD_MAX);
		zpos = -1;
		if (pick < 35) begin
			if ($urandom_range(3) == 0)
				zpos = $urandom_range(len);
			send_frame(text_cfg, random_body(len, zpos, $urandom_range(9) == 0), 1'b0);
		end else if (pick < 55) begin
			if ($urandom_range(2) == 0)
				zpos = 0;
			send_frame(lamp_cfg, random_body(len, zpos, 1'b1), 1'b0);
		end else if (pick < 65) begin
			send_frame(8'($urandom), random_body(len, -1, 1'b1), 1'b0);
		end else if (pick < 75) begin
			case ($urandom_range(2))
				0: cmd = text_cfg;
				1: cmd = lamp_cfg;
				default: cmd = 8'($urandom);
			endcase
			send_frame(cmd, random_body(len, -1, 1'b1), 1'b1);
		end else if (pick < 83) begin
			park_parser();
			send_word(hdr_cfg);
			send_word(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 4)) send_word(8'($urandom));
		end else begin
			// truncated frame; the next frame parks the parser first
			park_parser();
			send_word(hdr_cfg);
			repeat ($urandom_range(1, 5)) send_word(8'($urandom));
		end
	endtask

	task automatic run_traffic(input int tx_pct, input int rx_pct, input int word_goal);
		int start;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		start = parsed_words;
		while (parsed_words - start < word_goal)
			random_episode();
	endtask

	// Text frames: short, empty, leading zero, inner zero, longer run
	task automatic test_text_frames();
		byte_q_t body;
		body = {8'h48, 8'h69, 8'h21};
		send_frame(text_cfg, body, 1'b0);
		body = {};
		send_frame(text_cfg, body, 1'b0);
		body = {8'h00, 8'h41, 8'h42};
		send_frame(text_cfg, body, 1'b0);
		body = {8'h7F, 8'h00, 8'h55};
		send_frame(text_cfg, body, 1'b0);
		body = random_body(8, -1, 1'b0);
		body[0] = 8'hFF;
		body[7] = 8'h01;
		send_frame(text_cfg, body, 1'b0);
	endtask

	// Lamp frames: on, zero length from the store, off, zero length again
	task automatic test_lamp_frames();
		byte_q_t body;
		body = {8'h01};
		send_frame(lamp_cfg, body, 1'b0);
		body = {};
		send_frame(lamp_cfg, body, 1'b0);
		body = {8'h00, 8'h05};
		send_frame(lamp_cfg, body, 1'b0);
		body = {};
		send_frame(lamp_cfg, body, 1'b0);
	endtask

	// Ignored words, unknown command, sum error, length limits, header inside a frame
	task automatic test_other_results();
		byte_q_t body;
		send_word(8'h00);
		send_word(8'hFF);
		send_word(8'h7F);
		body = {hdr_cfg, 8'h33};
		send_frame(8'h00, body, 1'b0);
		body = {8'h12};
		send_frame(text_cfg, body, 1'b1);
		send_word(hdr_cfg);
		send_word(8'(PAYLOAD_MAX + 1));
		send_word(hdr_cfg);
		send_word(8'hFF);
		// header as the command word and as the sum word
		body = {8'h02};
		send_frame(hdr_cfg, body, 1'b0);
		body = {8'hFE - 8'h11};
		send_frame(8'h10, body, 1'b0);
	endtask

	// Register extremes, and text and lamp codes made equal
	task automatic test_register_settings();
		byte_q_t body;
		apply_settings(8'h00, 8'hFF, 8'h00);
		body = {8'h0A};
		send_frame(text_cfg, body, 1'b0);
		body = {8'h03};
		send_frame(lamp_cfg, body, 1'b0);
		apply_settings(8'h5A, 8'hC3, 8'hC3);
		body = {8'h09};
		send_frame(text_cfg, body, 1'b0);
		body = {};
		send_frame(lamp_cfg, body, 1'b0);
	endtask

	// Long receiver hold-off while text frames keep coming, then a full pause
	task automatic test_output_backpressure();
		apply_settings(HEADER_RST, TEXT_CMD_RST, LAMP_CMD_RST);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_len = 300;
		hold_req = 1'b1;
		repeat (2) send_frame(text_cfg, random_body(4, -1, 1'b0), 1'b0);
		in_valid <= 1'b0;
		while (hold_req || hold_left > 0)
			@(posedge clk);
		drain_results();
		send_frame(text_cfg, random_body(3, -1, 1'b0), 1'b0);
	endtask

	task automatic test_random_traffic();
		run_traffic(0, 0, 4);
		apply_settings(8'h00, 8'hFF, 8'h00);
		run_traffic(54, 0, 4);
		apply_settings(8'hFF, 8'h00, 8'hFF);
		run_traffic(0, 54, 4);
		apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
		run_traffic(12, 12, 4);
	endtask

	// Drive out_ready: random stalls, or a counted long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = hold_len;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		parse_result_t got;
		parse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, command_code, text_byte, byte_valid, byte_index, last, lamp_on};
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display({"unexpected result word: status %0d cmd %02h text %02h",
						" v %0b idx %0d last %0b lamp %0b"},
						got.status, got.command_code, got.text_byte, got.byte_valid,
						got.byte_index, got.last, got.lamp_on);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display({"mismatch: status %0d/%0d cmd %02h/%02h text %02h/%02h",
							" v %0b/%0b idx %0d/%0d last %0b/%0b lamp %0b/%0b (exp/got)"},
							want.status, got.status, want.command_code, got.command_code,
							want.text_byte, got.text_byte, want.byte_valid, got.byte_valid,
							want.byte_index, got.byte_index, want.last, got.last,
							want.lamp_on, got.lamp_on);
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_text_frames();
		test_lamp_frames();
		test_other_results();
		test_register_settings();
		test_output_backpressure();
		test_random_traffic();
		park_parser();
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule
